FILE: rtl/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and codes for the dual stack block with one shared store.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int DSS_DEPTH      = 16;
    localparam int DSS_DATA_W     = 32;
    localparam int DSS_OP_W       = 3;
    localparam int DSS_STATUS_W   = 2;

    localparam logic [DSS_OP_W-1:0] OP_PUSH_ONE = 3'd0;
    localparam logic [DSS_OP_W-1:0] OP_PUSH_TWO = 3'd1;
    localparam logic [DSS_OP_W-1:0] OP_POP_ONE  = 3'd2;
    localparam logic [DSS_OP_W-1:0] OP_POP_TWO  = 3'd3;
    localparam logic [DSS_OP_W-1:0] OP_LIST_ONE = 3'd4;
    localparam logic [DSS_OP_W-1:0] OP_LIST_TWO = 3'd5;

    localparam logic [DSS_STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [DSS_STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [DSS_STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        OPK_NONE = 2'd0,
        OPK_PUSH = 2'd1,
        OPK_POP  = 2'd2,
        OPK_LIST = 2'd3
    } op_kind_t;

    typedef enum logic [2:0] {
        OUT_PUSH  = 3'd0,
        OUT_FULL  = 3'd1,
        OUT_EMPTY = 3'd2,
        OUT_POP   = 3'd3,
        OUT_LIST  = 3'd4
    } out_sel_t;

    typedef struct packed {
        logic     take;
        logic     push_wr;
        logic     pop_rd;
        logic     list_start;
        logic     list_next;
        logic     out_load;
        out_sel_t out_sel;
    } dss_cmd_t;

    typedef struct packed {
        op_kind_t op_kind;
        logic     full;
        logic     empty;
        logic     out_free;
        logic     idx_zero;
    } dss_sts_t;

endpackage

FILE: rtl/dual_stack_shared_array.sv
// ----------------------------------------------------------------------------
// dual_stack_shared_array
// Two LIFO stacks in one shared store; stack one grows from the bottom and
// stack two from the top.
// ----------------------------------------------------------------------------
// One item is handled at a time. A push gives its result after the execute
// state, a pop after the execute state and a store read, since the store
// read is registered, and a list of n elements gives its first result after
// the execute state and its first store read, then one result a cycle while
// the output is not stalled. The next item is taken in the cycle after the
// last result of the current one enters the output register, so a waiting
// result does not hold up the input. Op codes 6 and 7 produce no result.
// ----------------------------------------------------------------------------
module dual_stack_shared_array
    import dss_pkg::*;
#(
    parameter int DEPTH = DSS_DEPTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [DSS_OP_W-1:0]            op,
    input  logic signed [DSS_DATA_W-1:0]   data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [DSS_DATA_W-1:0]   value,
    output logic [DSS_STATUS_W-1:0]        status,
    output logic                           last
);

    dss_cmd_t cmd;
    dss_sts_t sts;

    dss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    dss_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .data      (data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .status    (status),
        .last      (last),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

FILE: rtl/dss_ctrl.sv
// ----------------------------------------------------------------------------
// dss_ctrl
// Controller state machine: sequences accept, execute, store read and
// list walk, and drives the datapath through a command struct.
// ----------------------------------------------------------------------------
module dss_ctrl
    import dss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dss_sts_t sts,
    output dss_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_POPRD = 4'b0100,
        S_LIST  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.out_sel    = OUT_PUSH;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (sts.op_kind)
                    OPK_PUSH:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = sts.full ? OUT_FULL : OUT_PUSH;
                            cmd.push_wr  = !sts.full;
                            state_next   = S_IDLE;
                        end
                    end
                    OPK_POP:
                    begin
                        if (sts.empty)
                        begin
                            if (sts.out_free)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_sel  = OUT_EMPTY;
                                state_next   = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.pop_rd = 1'b1;
                            state_next = S_POPRD;
                        end
                    end
                    OPK_LIST:
                    begin
                        if (sts.empty)
                        begin
                            if (sts.out_free)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_sel  = OUT_EMPTY;
                                state_next   = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.list_start = 1'b1;
                            state_next     = S_LIST;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_POPRD:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_POP;
                    state_next   = S_IDLE;
                end
            end
            S_LIST:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_LIST;
                    if (sts.idx_zero)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.list_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/dss_dp.sv
// ----------------------------------------------------------------------------
// dss_dp
// Datapath: item registers, the shared store, both stack counts, the list
// index and the output register.
// ----------------------------------------------------------------------------
module dss_dp
    import dss_pkg::*;
#(
    parameter int DEPTH = DSS_DEPTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [DSS_OP_W-1:0]            op,
    input  logic signed [DSS_DATA_W-1:0]   data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [DSS_DATA_W-1:0]   value,
    output logic [DSS_STATUS_W-1:0]        status,
    output logic                           last,
    input  dss_cmd_t                       cmd,
    output dss_sts_t                       sts
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] TOP_ADDR = AW'(DEPTH - 1);

    logic [DSS_DATA_W-1:0]   mem [DEPTH];

    logic [DSS_OP_W-1:0]     op_reg;
    logic [DSS_DATA_W-1:0]   data_reg;
    logic [CW-1:0]           cnt_one_reg;
    logic [CW-1:0]           cnt_two_reg;
    logic [AW-1:0]           idx_reg;
    logic [DSS_DATA_W-1:0]   rd_data_reg;
    logic                    out_valid_reg;
    logic [DSS_DATA_W-1:0]   value_reg;
    logic [DSS_STATUS_W-1:0] status_reg;
    logic                    last_reg;

    logic                    sel;
    logic [CW-1:0]           n_sel;
    logic [CW-1:0]           n_top;
    logic [CW:0]             total;
    logic [AW-1:0]           wr_k;
    logic [AW-1:0]           rd_k;
    logic [AW-1:0]           wr_addr;
    logic [AW-1:0]           rd_addr;
    logic                    rd_en;
    logic                    out_free;

    assign sel      = op_reg[0];
    assign n_sel    = sel ? cnt_two_reg : cnt_one_reg;
    assign n_top    = n_sel - 1'b1;
    assign total    = {1'b0, cnt_one_reg} + {1'b0, cnt_two_reg};
    assign wr_k     = n_sel[AW-1:0];
    assign rd_k     = cmd.list_next ? (idx_reg - 1'b1) : n_top[AW-1:0];
    assign wr_addr  = sel ? (TOP_ADDR - wr_k) : wr_k;
    assign rd_addr  = sel ? (TOP_ADDR - rd_k) : rd_k;
    assign rd_en    = cmd.pop_rd || cmd.list_start || cmd.list_next;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        sts.full     = (total >= (CW + 1)'(DEPTH));
        sts.empty    = (n_sel == '0);
        sts.out_free = out_free;
        sts.idx_zero = (idx_reg == '0);
        if (op_reg inside {OP_PUSH_ONE, OP_PUSH_TWO})
        begin
            sts.op_kind = OPK_PUSH;
        end
        else if (op_reg inside {OP_POP_ONE, OP_POP_TWO})
        begin
            sts.op_kind = OPK_POP;
        end
        else if (op_reg inside {OP_LIST_ONE, OP_LIST_TWO})
        begin
            sts.op_kind = OPK_LIST;
        end
        else
        begin
            sts.op_kind = OPK_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_wr)
        begin
            mem[wr_addr] <= data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            data_reg <= data;
        end
        if (cmd.list_start || cmd.list_next)
        begin
            idx_reg <= rd_k;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg      <= '0;
            cnt_one_reg <= '0;
            cnt_two_reg <= '0;
        end
        else
        begin
            if (cmd.take)
            begin
                op_reg <= op;
            end
            if (cmd.push_wr)
            begin
                if (sel)
                begin
                    cnt_two_reg <= cnt_two_reg + 1'b1;
                end
                else
                begin
                    cnt_one_reg <= cnt_one_reg + 1'b1;
                end
            end
            else if (cmd.pop_rd)
            begin
                if (sel)
                begin
                    cnt_two_reg <= n_top;
                end
                else
                begin
                    cnt_one_reg <= n_top;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (cmd.out_sel)
                OUT_PUSH:
                begin
                    value_reg  <= data_reg;
                    status_reg <= ST_OK;
                    last_reg   <= 1'b1;
                end
                OUT_FULL:
                begin
                    value_reg  <= '0;
                    status_reg <= ST_FULL;
                    last_reg   <= 1'b1;
                end
                OUT_EMPTY:
                begin
                    value_reg  <= '0;
                    status_reg <= ST_EMPTY;
                    last_reg   <= 1'b1;
                end
                OUT_POP:
                begin
                    value_reg  <= rd_data_reg;
                    status_reg <= ST_OK;
                    last_reg   <= 1'b1;
                end
                OUT_LIST:
                begin
                    value_reg  <= rd_data_reg;
                    status_reg <= ST_OK;
                    last_reg   <= (idx_reg == '0);
                end
                default:
                begin
                    value_reg  <= '0;
                    status_reg <= ST_OK;
                    last_reg   <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    // The two stacks together never hold more words than the store has.
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total <= (CW + 1)'(DEPTH))
        else $error("stack counts exceed store depth");

    // A result never overwrites one that is still waiting to be taken.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("output register overwritten");

    // A push is written only when the store has room.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_wr |-> !sts.full)
        else $error("push into full store");

    // A store read for pop or list never starts on an empty stack.
    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop_rd || cmd.list_start) |-> !sts.empty)
        else $error("read from empty stack");

endmodule
